@@ hw/rtl/cst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the subtree revocation cover
// tree geometry, request codes, sequencer states and inter-module structs
// ----------------------------------------------------------------------------
package cst_pkg;

	// tree geometry
	localparam int DEPTH       = 5;
	localparam int NUM_USERS   = 1 << DEPTH;
	localparam int NUM_NODES   = (2 << DEPTH) - 1;
	localparam int NODE_W      = DEPTH + 1;
	localparam int LVL_W       = $clog2(DEPTH + 1);
	localparam int IDX_W       = 6;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		REQ_REVOKE = 2'd0,
		REQ_PATH   = 2'd1,
		REQ_COVER  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_REVOKE,
		ST_PATH,
		ST_COVER,
		ST_FLUSH,
		ST_ACK
	} state_t;

	typedef enum logic [1:0] {
		OP_PARENT,
		OP_LEFT,
		OP_NEXT,
		OP_SHR
	} alu_op_t;

	// node arithmetic works on one-based heap numbers (node index + 1)
	typedef struct packed {
		logic [NODE_W-1:0] m;
		logic              wrap;
	} alu_res_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		logic              wdata;
		logic [NODE_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] node;
		logic             has;
		logic             last;
	} res_t;

	// one-based heap number to emitted node index, masked to the port width
	function automatic logic [IDX_W-1:0] to_index(input logic [NODE_W-1:0] m);
		logic [NODE_W-1:0]       n;
		logic [NODE_W+IDX_W-1:0] w;
		n = m - NODE_W'(1);
		w = (NODE_W + IDX_W)'(n);
		return w[IDX_W-1:0];
	endfunction

endpackage

@@ hw/rtl/cst_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module cst_ram #(
	parameter int DATA_W = 1,
	parameter int WORDS  = 2,
	localparam int ADDR_W = $clog2(WORDS)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/cst_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_alu: shared node arithmetic unit
// parent, left child, next node after a climb, and level shift on heap numbers
// ----------------------------------------------------------------------------
module cst_alu import cst_pkg::*; (
	input  alu_op_t           op,
	input  logic [NODE_W-1:0] m,
	input  logic [LVL_W-1:0]  amt,
	output alu_res_t          res
);

	localparam int SH_W = $clog2(NODE_W + 1);

	logic [NODE_W:0]   s;
	logic [SH_W-1:0]   tz;
	logic              found;
	logic [NODE_W-1:0] nxt;

	// climbing past right children then stepping right equals
	// (m + 1) with its trailing zeros shifted off
	always_comb begin
		s     = {1'b0, m} + (NODE_W + 1)'(1);
		tz    = '0;
		found = 1'b0;
		for (int i = 0; i <= NODE_W; i++) begin
			if (!found && s[i]) begin
				tz    = SH_W'(i);
				found = 1'b1;
			end
		end
		nxt = NODE_W'(s >> tz);
	end

	always_comb begin
		res.wrap = ((s & (s - (NODE_W + 1)'(1))) == '0);
		case (op)
			OP_PARENT: res.m = m >> 1;
			OP_LEFT:   res.m = {m[NODE_W-2:0], 1'b0};
			OP_NEXT:   res.m = nxt;
			OP_SHR:    res.m = m >> amt;
			default:   res.m = m;
		endcase
	end

endmodule

@@ hw/rtl/cst_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_seq: request sequencer
// clear pass, revoke, path and cover walks around the shared node unit
// ----------------------------------------------------------------------------
module cst_seq import cst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] req_type,
	input  logic [4:0] user_id,
	input  logic       rd_allowed,
	output mem_req_t   mem,
	output res_t       res,
	output logic       busy
);

	state_t            state_q, state_d;
	logic [NODE_W-1:0] m_q;
	logic [LVL_W-1:0]  k_q;
	logic [NODE_W-1:0] clr_q;
	logic [NODE_W-1:0] pend_q;
	logic              pend_v_q;
	logic [CNT_W-1:0]  cnt_q;
	res_t              res_q, res_d;

	req_t              req;
	logic              accept;
	logic              in_range;
	logic [NODE_W-1:0] leaf_m;
	logic              walk_on;
	logic              cov_end;
	alu_op_t           op;
	logic [LVL_W-1:0]  amt;
	alu_res_t          alu;

	assign req      = req_t'(req_type);
	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign in_range = (32'(user_id) < NUM_USERS);
	assign leaf_m   = NODE_W'(NUM_USERS) + NODE_W'(user_id);
	// step on unless an inner node is revoked
	assign walk_on  = rd_allowed || m_q[NODE_W-1];
	assign cov_end  = (walk_on && alu.wrap) ||
	                  (rd_allowed && (cnt_q == CNT_W'(MAX_RESULTS - 1)));
	assign amt      = LVL_W'(DEPTH) - k_q;
	assign res      = res_q;

	always_comb begin
		case (state_q)
			ST_REVOKE: op = OP_PARENT;
			ST_PATH:   op = OP_SHR;
			ST_COVER:  op = walk_on ? OP_NEXT : OP_LEFT;
			default:   op = OP_PARENT;
		endcase
	end

	cst_alu u_alu (
		.op  (op),
		.m   (m_q),
		.amt (amt),
		.res (alu)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (clr_q == NODE_W'(NUM_NODES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (req)
						REQ_REVOKE: state_d = in_range ? ST_REVOKE : ST_ACK;
						REQ_PATH:   state_d = in_range ? ST_PATH : ST_ACK;
						REQ_COVER:  state_d = ST_COVER;
						default:    state_d = ST_ACK;
					endcase
				end
			end
			ST_REVOKE: begin
				if (m_q == NODE_W'(1)) state_d = ST_IDLE;
			end
			ST_PATH: begin
				if (k_q == LVL_W'(DEPTH)) state_d = ST_IDLE;
			end
			ST_COVER: begin
				if (cov_end) state_d = ST_FLUSH;
			end
			ST_FLUSH: state_d = ST_IDLE;
			ST_ACK:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory port and result beat
	always_comb begin
		mem.we    = 1'b0;
		mem.waddr = m_q - NODE_W'(1);
		mem.wdata = 1'b0;
		mem.raddr = alu.m - NODE_W'(1);
		res_d     = '0;
		case (state_q)
			ST_INIT: begin
				mem.we    = 1'b1;
				mem.waddr = clr_q;
				mem.wdata = 1'b1;
			end
			ST_IDLE: begin
				mem.raddr = '0;
			end
			ST_REVOKE: begin
				mem.we = 1'b1;
				if (m_q == NODE_W'(1)) begin
					res_d.valid = 1'b1;
					res_d.last  = 1'b1;
				end
			end
			ST_PATH: begin
				res_d.valid = 1'b1;
				res_d.node  = to_index(alu.m);
				res_d.has   = 1'b1;
				res_d.last  = (k_q == LVL_W'(DEPTH));
			end
			ST_COVER: begin
				// a new find releases the one held back
				if (rd_allowed && pend_v_q) begin
					res_d.valid = 1'b1;
					res_d.node  = to_index(pend_q);
					res_d.has   = 1'b1;
				end
			end
			ST_FLUSH: begin
				res_d.valid = 1'b1;
				res_d.node  = pend_v_q ? to_index(pend_q) : '0;
				res_d.has   = pend_v_q;
				res_d.last  = 1'b1;
			end
			ST_ACK: begin
				res_d.valid = 1'b1;
				res_d.last  = 1'b1;
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			clr_q    <= '0;
			pend_v_q <= 1'b0;
			cnt_q    <= '0;
			res_q    <= '0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			case (state_q)
				ST_INIT: clr_q <= clr_q + NODE_W'(1);
				ST_IDLE: begin
					if (accept) begin
						pend_v_q <= 1'b0;
						cnt_q    <= '0;
					end
				end
				ST_COVER: begin
					if (rd_allowed) begin
						pend_v_q <= 1'b1;
						cnt_q    <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					m_q <= (req == REQ_COVER) ? NODE_W'(1) : leaf_m;
					k_q <= '0;
				end
			end
			ST_REVOKE: m_q <= alu.m;
			ST_PATH:   k_q <= k_q + LVL_W'(1);
			ST_COVER: begin
				if (rd_allowed) pend_q <= m_q;
				m_q <= alu.m;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/complete_subtree_revocation_cover.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complete_subtree_revocation_cover: key tree revocation and cover lister
// one allowed bit per node of a complete binary tree, heap ordered
// ----------------------------------------------------------------------------
// usage
//   a request beat (req_type, user_id) is taken on a clock edge with start
//   high and busy low; busy stays high until the request's last result beat
//   is on the result ports
//   result beats (node_index, has_node, last) show for exactly one cycle
//   with result_valid high; the receiver cannot stall them
//   revoke: clears the user's leaf-to-root path, one node write per cycle,
//     then one acknowledge beat (has_node 0, last 1)
//   path: DEPTH+1 beats root first, one per cycle, last on the leaf
//   cover: depth-first walk at one node per cycle through the shared node
//     unit and the single read port of the bit ram, then a flush step
//     releases the held-back final beat; an empty cover gives one beat
//     with has_node 0
//   unused codes and users beyond the tree give one acknowledge beat
//   after reset a clearing pass sets all 2^(DEPTH+1)-1 bits
//   with busy high before the first request is taken
// ----------------------------------------------------------------------------
module complete_subtree_revocation_cover import cst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       req_type,
	input  logic [4:0]       user_id,
	output logic             result_valid,
	output logic [IDX_W-1:0] node_index,
	output logic             has_node,
	output logic             last
);

	mem_req_t mem;
	res_t     res;
	logic     rdata;

	// allowed bits, one per node
	cst_ram #(
		.DATA_W (1),
		.WORDS  (NUM_NODES)
	) u_bits (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	// sequencer with the shared node unit
	cst_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.user_id    (user_id),
		.rd_allowed (rdata),
		.mem        (mem),
		.res        (res),
		.busy       (busy)
	);

	// result beat straight from the output register
	assign result_valid = res.valid;
	assign node_index   = res.node;
	assign has_node     = res.has;
	assign last         = res.last;

	// an acknowledge or empty cover beat always closes its request
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !has_node) |-> last)
		else $error("beat without node not marked last");

	// the final beat coincides with the block going free, and only it
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last == !busy))
		else $error("last beat and busy disagree");

	// a taken request always occupies the sequencer
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken without going busy");

	// emitted nodes lie inside the tree
	a_node_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && has_node) |-> ((NUM_NODES > 64) || (int'(node_index) < NUM_NODES)))
		else $error("node index outside the tree");

endmodule
